@@ rtl/ppia_pkg.sv @@
// ppia_pkg: shared constants and types for the periodic profile interval averager
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ppia_pkg;

   localparam int MAX_BINS  = 4096;
   localparam int TAB_DEPTH = MAX_BINS + 1;
   localparam int IDX_W     = 13;
   localparam int PROF_W    = 24;
   localparam int ANT_W     = 32;
   localparam int PHASE_W   = 48;
   localparam int FRAC_W    = 32;
   localparam int VAL_W     = 32;

   // divider operand widths: |integral| and bins times phase advance
   localparam int NUM_W = 51;
   localparam int DEN_W = 60;
   localparam int QUO_W = 54;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_NEXT  = 2'd2;

   localparam logic [1:0] CSR_BINS   = 2'd0;
   localparam logic [1:0] CSR_GAIN   = 2'd1;
   localparam logic [1:0] CSR_OFFSET = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;

endpackage

@@ rtl/ppia_tables.sv @@
// ppia_tables: profile and antiderivative table memories, one write port,
// one registered read port each; depends on ppia_pkg
`timescale 1ns / 1ps

module ppia_tables
   import ppia_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  idx_type           wr_addr,
   input  logic [PROF_W-1:0] wr_prof,
   input  logic [ANT_W-1:0]  wr_ant,
   input  idx_type           prof_addr,
   input  idx_type           ant_addr,
   output logic [PROF_W-1:0] prof_rdata,
   output logic [ANT_W-1:0]  ant_rdata
);

   logic [PROF_W-1:0] prof_mem [TAB_DEPTH];
   logic [ANT_W-1:0]  ant_mem  [TAB_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prof_mem[wr_addr] <= wr_prof;
         ant_mem[wr_addr]  <= wr_ant;
      end
   end

   always_ff @(posedge clock) begin
      prof_rdata <= prof_mem[prof_addr];
      ant_rdata  <= ant_mem[ant_addr];
   end

endmodule

@@ rtl/ppia_div.sv @@
// ppia_div: radix-2 restoring divider, floor(num * 2^16 / den), one bit a cycle
// flags quotients of 2^54 and above; depends on ppia_pkg
`timescale 1ns / 1ps

module ppia_div
   import ppia_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic             big,
   output logic [QUO_W-1:0] quot
);

   localparam int HI_W = NUM_W - 38;

   logic             busy_ff;
   logic             done_ff;
   logic             big_ff;
   logic [5:0]       cnt_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [QUO_W-1:0] dvd_ff;
   logic [QUO_W-1:0] quot_ff;

   logic [DEN_W:0]   trial;
   logic             take;
   logic [DEN_W-1:0] hi_part;

   assign hi_part = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:38]};
   assign trial   = {rem_ff, dvd_ff[QUO_W-1]};
   assign take    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (big_ff || cnt_ff == 6'd1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff  <= den;
         rem_ff  <= hi_part;
         dvd_ff  <= {num[37:0], 16'b0};
         big_ff  <= hi_part >= den;
         cnt_ff  <= 6'(QUO_W);
         quot_ff <= '0;
      end else if (busy_ff && !big_ff) begin
         rem_ff  <= take ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         dvd_ff  <= {dvd_ff[QUO_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUO_W-2:0], take};
         cnt_ff  <= cnt_ff - 6'd1;
      end
   end

   assign done = done_ff;
   assign big  = big_ff;
   assign quot = big_ff ? '0 : quot_ff;

endmodule

@@ rtl/periodic_profile_interval_average.sv @@
// periodic_profile_interval_average: top level, sequencer, run state and scaling
// depends on ppia_pkg, ppia_tables, ppia_div
`timescale 1ns / 1ps

// One item at a time. A table load (action 0) gives no result. A phase
// boundary goes through bin location, two reads from each table memory, a
// chain of registered multiplies, then a 54-step one-bit-a-cycle division of
// the interval integral by the phase advance; a zero or negative advance
// goes straight to an error result instead. The result waits in an
// output register; the next item is accepted once it has been handed over
// to that register. Tables have no reset: entries must be loaded before use.
module periodic_profile_interval_average
   import ppia_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [IDX_W-1:0]   req_table_index,
   input  logic [PROF_W-1:0]  req_profile_value,
   input  logic [ANT_W-1:0]   req_antider_value,
   input  logic [PHASE_W-1:0] req_phase_value,
   input  logic [VAL_W-1:0]   req_base_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VAL_W-1:0]   rsp_sample_value,
   output logic               rsp_phase_error,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [VAL_W-1:0]   csr_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOC    = 4'd1;
   localparam logic [3:0] S_RD0    = 4'd2;
   localparam logic [3:0] S_RD1    = 4'd3;
   localparam logic [3:0] S_RD2    = 4'd4;
   localparam logic [3:0] S_CHK    = 4'd5;
   localparam logic [3:0] S_MUL1   = 4'd6;
   localparam logic [3:0] S_MUL2   = 4'd7;
   localparam logic [3:0] S_MUL3   = 4'd8;
   localparam logic [3:0] S_SUM    = 4'd9;
   localparam logic [3:0] S_DSTART = 4'd10;
   localparam logic [3:0] S_DIV    = 4'd11;
   localparam logic [3:0] S_GMUL   = 4'd12;
   localparam logic [3:0] S_SCALE  = 4'd13;
   localparam logic [3:0] S_ADDC   = 4'd14;
   localparam logic [3:0] S_FIN    = 4'd15;

   logic [3:0] state_ff, state_in;

   // configuration
   logic [IDX_W-1:0] bins_ff;
   logic [VAL_W-1:0] gain_ff;
   logic [VAL_W-1:0] offset_ff;

   // item
   logic [1:0]         act_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [VAL_W-1:0]   base_ff;

   // run state
   logic               run_open_ff;
   logic [PHASE_W-1:0] last_phase_ff;
   logic [IDX_W-1:0]   last_bin_ff;
   logic [FRAC_W-1:0]  last_frac_ff;
   logic [PROF_W-1:0]  last_low_ff;
   logic [PROF_W-1:0]  last_high_ff;

   // datapath
   logic [IDX_W-1:0]   b_ff;
   logic [FRAC_W-1:0]  u_ff;
   logic [PHASE_W-1:0] delta_ff;
   logic [PROF_W-1:0]  lo1_ff, hi1_ff;
   logic [ANT_W-1:0]   ab1_ff, aia_ff;
   logic signed [57:0] prod0_ff, prod1_ff;
   logic [36:0]        dplo_ff;
   logic [35:0]        dphi_ff;
   logic signed [25:0] l0_ff, l1_ff;
   logic [DEN_W-1:0]   dp_ff;
   logic signed [59:0] t0_ff, t1_ff;
   logic signed [51:0] integral_ff;
   logic [58:0]        phi_ff, plo_ff;
   logic signed [35:0] sh_ff;
   logic               sat_ff, neg_ff;
   logic [VAL_W-1:0]   res_value_ff;
   logic               res_err_ff;
   logic               rsp_valid_ff;
   logic [VAL_W-1:0]   rsp_value_ff;
   logic               rsp_err_ff;

   logic req_fire;
   logic same_bin;
   logic [IDX_W-1:0] n_eff;
   logic [44:0] loc_prod;
   logic [IDX_W-1:0] loc_bin;
   logic [IDX_W-1:0] ia;

   logic [32:0] sum_a;
   logic [FRAC_W-1:0] w0;
   logic signed [24:0] d0, d1;
   logic signed [32:0] w0s, w1s;
   logic signed [57:0] prod0_in, prod1_in;
   logic signed [33:0] width0, u1s;
   logic signed [59:0] t0_in, t1_in;
   logic signed [32:0] ad;
   logic signed [51:0] integral_in;
   logic [NUM_W-1:0] div_num;
   logic [31:0] gmag;
   logic [85:0] full;
   logic signed [55:0] sprod;
   logic signed [37:0] total;
   logic [VAL_W-1:0] clamped;

   logic [IDX_W-1:0] prof_addr, ant_addr;
   logic [PROF_W-1:0] prof_rdata;
   logic [ANT_W-1:0] ant_rdata;
   logic tab_wr;

   logic div_done, div_big;
   logic [QUO_W-1:0] div_quot;

   assign req_ready = state_ff == S_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign tab_wr = req_fire && req_action == ACT_LOAD
                   && req_table_index <= IDX_W'(MAX_BINS);

   // clamp the bin count to [2, MAX_BINS]
   always_comb begin
      if (bins_ff < IDX_W'(2)) begin
         n_eff = IDX_W'(2);
      end else if (bins_ff > IDX_W'(MAX_BINS)) begin
         n_eff = IDX_W'(MAX_BINS);
      end else begin
         n_eff = bins_ff;
      end
   end

   assign loc_prod = 45'(phase_ff[FRAC_W-1:0]) * 45'(n_eff);
   assign loc_bin  = (loc_prod[44:32] > IDX_W'(MAX_BINS - 1)) ? IDX_W'(MAX_BINS - 1)
                     : loc_prod[44:32];
   assign ia       = (last_bin_ff + IDX_W'(1) > IDX_W'(MAX_BINS)) ? IDX_W'(MAX_BINS)
                     : last_bin_ff + IDX_W'(1);
   assign same_bin = b_ff == last_bin_ff;

   assign prof_addr = (state_ff == S_RD0) ? b_ff : b_ff + IDX_W'(1);
   assign ant_addr  = (state_ff == S_RD0) ? b_ff : ia;

   // midpoint weights and interpolation slopes
   assign sum_a    = {1'b0, last_frac_ff} + {1'b0, u_ff};
   assign w0       = same_bin ? sum_a[32:1] : {1'b1, last_frac_ff[FRAC_W-1:1]};
   assign w0s      = $signed({1'b0, w0});
   assign w1s      = $signed({2'b0, u_ff[FRAC_W-1:1]});
   assign d0       = $signed({last_high_ff[PROF_W-1], last_high_ff})
                     - $signed({last_low_ff[PROF_W-1], last_low_ff});
   assign d1       = $signed({hi1_ff[PROF_W-1], hi1_ff}) - $signed({lo1_ff[PROF_W-1], lo1_ff});
   assign prod0_in = w0s * d0;
   assign prod1_in = w1s * d1;

   assign width0 = same_bin ? $signed({2'b0, u_ff}) - $signed({2'b0, last_frac_ff})
                   : $signed(34'h1_0000_0000 - {2'b0, last_frac_ff});
   assign u1s    = $signed({2'b0, u_ff});
   assign t0_in  = width0 * l0_ff;
   assign t1_in  = u1s * l1_ff;

   assign ad = $signed({ab1_ff[ANT_W-1], ab1_ff}) - $signed({aia_ff[ANT_W-1], aia_ff});
   assign integral_in = same_bin ? $signed({{8{t0_ff[59]}}, t0_ff[59:16]})
                        : $signed({{8{t0_ff[59]}}, t0_ff[59:16]})
                          + $signed({{3{ad[32]}}, ad, 16'b0})
                          + $signed({{8{t1_ff[59]}}, t1_ff[59:16]});

   assign div_num = integral_ff[51] ? NUM_W'(-integral_ff) : integral_ff[NUM_W-1:0];
   assign gmag    = gain_ff[31] ? 32'(-gain_ff) : gain_ff;

   assign full  = {phi_ff, 27'b0} + {27'b0, plo_ff};
   assign sprod = neg_ff ? -$signed({2'b0, full[53:0]}) : $signed({2'b0, full[53:0]});

   assign total = $signed({{2{sh_ff[35]}}, sh_ff})
                  + $signed({{6{offset_ff[31]}}, offset_ff})
                  + $signed({{6{base_ff[31]}}, base_ff});

   always_comb begin
      if (sat_ff) begin
         clamped = neg_ff ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if (total > 38'sh0_7fff_ffff) begin
         clamped = 32'h7fff_ffff;
      end else if (total < -38'sh0_8000_0000) begin
         clamped = 32'h8000_0000;
      end else begin
         clamped = total[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_action == ACT_START || req_action == ACT_NEXT)) begin
               state_in = S_LOC;
            end
         end
         S_LOC:    state_in = S_RD0;
         S_RD0:    state_in = S_RD1;
         S_RD1:    state_in = S_RD2;
         S_RD2:    state_in = S_CHK;
         S_CHK: begin
            if (act_ff == ACT_START || !run_open_ff) begin
               state_in = S_IDLE;
            end else if (delta_ff == '0 || delta_ff[PHASE_W-1]) begin
               state_in = S_FIN;
            end else begin
               state_in = S_MUL1;
            end
         end
         S_MUL1:   state_in = S_MUL2;
         S_MUL2:   state_in = S_MUL3;
         S_MUL3:   state_in = S_SUM;
         S_SUM:    state_in = S_DSTART;
         S_DSTART: state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = S_GMUL;
            end
         end
         S_GMUL:   state_in = S_SCALE;
         S_SCALE:  state_in = S_ADDC;
         S_ADDC:   state_in = S_FIN;
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         run_open_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bins_ff       <= IDX_W'(256);
         gain_ff       <= 32'h0001_0000;
         offset_ff     <= '0;
         last_phase_ff <= '0;
         last_bin_ff   <= '0;
         last_frac_ff  <= '0;
         last_low_ff   <= '0;
         last_high_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BINS:   bins_ff   <= csr_data[IDX_W-1:0];
               CSR_GAIN:   gain_ff   <= csr_data;
               CSR_OFFSET: offset_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == S_CHK && (act_ff == ACT_START || !run_open_ff)) begin
            run_open_ff <= 1'b1;
         end
         // the run advances on a start (or on the first item of an unopened run) and on every delivered boundary
         if ((state_ff == S_CHK && (act_ff == ACT_START || !run_open_ff))
             || (state_ff == S_FIN && (!rsp_valid_ff || rsp_ready))) begin
            last_phase_ff <= phase_ff;
            last_bin_ff   <= b_ff;
            last_frac_ff  <= u_ff;
            last_low_ff   <= lo1_ff;
            last_high_ff  <= hi1_ff;
         end
         if (state_ff == S_FIN && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff   <= req_action;
         phase_ff <= req_phase_value;
         base_ff  <= req_base_value;
      end
      if (state_ff == S_LOC) begin
         b_ff     <= loc_bin;
         u_ff     <= loc_prod[31:0];
         delta_ff <= phase_ff - last_phase_ff;
      end
      if (state_ff == S_RD1) begin
         lo1_ff <= prof_rdata;
         ab1_ff <= ant_rdata;
      end
      if (state_ff == S_RD2) begin
         hi1_ff <= prof_rdata;
         aia_ff <= ant_rdata;
      end
      if (state_ff == S_CHK) begin
         res_value_ff <= '0;
         res_err_ff   <= 1'b1;
      end
      if (state_ff == S_MUL1) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
         dplo_ff  <= 37'(delta_ff[23:0]) * 37'(n_eff);
         dphi_ff  <= 36'(delta_ff[46:24]) * 36'(n_eff);
      end
      if (state_ff == S_MUL2) begin
         l0_ff <= $signed({{2{last_low_ff[PROF_W-1]}}, last_low_ff}) + $signed(prod0_ff[57:32]);
         l1_ff <= $signed({{2{lo1_ff[PROF_W-1]}}, lo1_ff}) + $signed(prod1_ff[57:32]);
         dp_ff <= {23'b0, dplo_ff} + {dphi_ff, 24'b0};
      end
      if (state_ff == S_MUL3) begin
         t0_ff <= t0_in;
         t1_ff <= t1_in;
      end
      if (state_ff == S_SUM) begin
         integral_ff <= integral_in;
      end
      if (state_ff == S_GMUL) begin
         phi_ff <= 59'(div_quot[53:27]) * 59'(gmag);
         plo_ff <= 59'(div_quot[26:0]) * 59'(gmag);
         neg_ff <= integral_ff[51] ^ gain_ff[31];
      end
      if (state_ff == S_SCALE) begin
         sat_ff <= (div_big && gmag != '0) || (full[85:54] != '0);
         sh_ff  <= sprod[55:20];
      end
      if (state_ff == S_ADDC) begin
         res_value_ff <= clamped;
         res_err_ff   <= 1'b0;
      end
      if (state_ff == S_FIN && (!rsp_valid_ff || rsp_ready)) begin
         rsp_value_ff <= res_value_ff;
         rsp_err_ff   <= res_err_ff;
      end
   end

   ppia_tables u_tables (
      .clock      (clock),
      .wr_en      (tab_wr),
      .wr_addr    (req_table_index),
      .wr_prof    (req_profile_value),
      .wr_ant     (req_antider_value),
      .prof_addr  (prof_addr),
      .ant_addr   (ant_addr),
      .prof_rdata (prof_rdata),
      .ant_rdata  (ant_rdata)
   );

   ppia_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DSTART),
      .num   (div_num),
      .den   (dp_ff),
      .done  (div_done),
      .big   (div_big),
      .quot  (div_quot)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;
   assign rsp_phase_error  = rsp_err_ff;

endmodule

@@ verif/tb_periodic_profile_interval_average.sv @@
// tb_periodic_profile_interval_average: self-checking testbench for the interval averager
// depends on ppia_pkg and periodic_profile_interval_average; compares every result
// with an in-bench predictor of the profile average, under random idling on both sides
`timescale 1ns / 1ps

module tb_periodic_profile_interval_average;
   import ppia_pkg::*;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          DRAIN_WAIT  = 100;
   localparam int          PHASE_ITEMS = 75;
   localparam int          NUM_PHASES  = 7;
   localparam int          FILL_TOP    = 512;
   localparam longint unsigned ONE_Q32 = 64'h1_0000_0000;
   localparam longint unsigned AVG_CAP = 64'h4000_0000_0000_0000;
   localparam logic [1:0]  ACT_NONE    = 2'd3;

   typedef struct {
      logic [VAL_W-1:0] value;
      logic             err;
   } sample_type;

   typedef struct {
      logic [1:0]         act;
      logic [IDX_W-1:0]   idx;
      logic [PROF_W-1:0]  prof;
      logic [ANT_W-1:0]   ant;
      logic [PHASE_W-1:0] ph;
      logic [VAL_W-1:0]   base;
      bit                 typed;
      logic [VAL_W-1:0]   t_value;
      logic               t_err;
   } step_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_action;
   logic [IDX_W-1:0]   req_table_index;
   logic [PROF_W-1:0]  req_profile_value;
   logic [ANT_W-1:0]   req_antider_value;
   logic [PHASE_W-1:0] req_phase_value;
   logic [VAL_W-1:0]   req_base_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [VAL_W-1:0]   rsp_sample_value;
   logic               rsp_phase_error;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [VAL_W-1:0]   csr_data;

   periodic_profile_interval_average u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_table_index   (req_table_index),
      .req_profile_value (req_profile_value),
      .req_antider_value (req_antider_value),
      .req_phase_value   (req_phase_value),
      .req_base_value    (req_base_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_phase_error   (rsp_phase_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // predictor state
   int               prof_mem [0:TAB_DEPTH-1];
   int               ant_mem  [0:TAB_DEPTH-1];
   logic [PHASE_W-1:0] run_phase;
   int               run_bin;
   longint unsigned  run_frac;
   longint           run_lo;
   longint           run_hi;
   bit               run_open;
   logic [IDX_W-1:0] bins_reg;
   int               gain_reg;
   int               offset_reg;

   sample_type       pending_samples [$];
   int               mismatches;
   int               cycles;
   bit               calm;
   bit               long_hold_req;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int eff_bins();
      int n;
      n = int'(bins_reg);
      if (n < 2) n = 2;
      if (n > MAX_BINS) n = MAX_BINS;
      return n;
   endfunction

   function automatic void split_phase(input logic [PHASE_W-1:0] ph, input int n,
                                       output int b, output longint unsigned f);
      longint unsigned x;
      x = longint'(ph[FRAC_W-1:0]) * longint'(n);
      b = int'(x >> FRAC_W);
      if (b > MAX_BINS - 1) b = MAX_BINS - 1;
      f = x & 64'hFFFF_FFFF;
   endfunction

   function automatic longint interp(input longint r0, input longint r1,
                                     input longint unsigned w);
      return r0 + ((longint'(w) * (r1 - r0)) >>> 32);
   endfunction

   function automatic longint unsigned scaled_quotient(input longint unsigned num,
                                                       input longint unsigned den);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      for (int i = 0; i < FRAC_W - 16; i++) begin
         if (q >= 64'h2000_0000_0000_0000) return AVG_CAP;
         q = q << 1;
         r = r << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   // advances the predictor by one item; produced tells whether a result follows
   function automatic void predict_average(input step_row_type it, output bit produced,
                                           output sample_type s);
      int n, b1, ia;
      longint unsigned u0, u1, delta, dp, mag, g;
      longint lo1, hi1, integral, prod, res;
      logic [PHASE_W-1:0] d48;
      bit neg;
      produced = 0;
      s.value = '0;
      s.err = 1'b0;
      n = eff_bins();
      if (it.act == ACT_LOAD) begin
         if (it.idx <= MAX_BINS) begin
            prof_mem[it.idx] = int'($signed(it.prof));
            ant_mem[it.idx] = int'($signed(it.ant));
         end
         return;
      end
      if (it.act == ACT_NONE) return;
      split_phase(it.ph, n, b1, u1);
      lo1 = prof_mem[b1];
      hi1 = prof_mem[b1 + 1];
      if (it.act == ACT_START || !run_open) begin
         run_open = 1;
      end else begin
         produced = 1;
         d48 = it.ph - run_phase;
         delta = {16'b0, d48};
         if (delta == 0 || delta[PHASE_W-1]) begin
            s.err = 1'b1;
         end else begin
            u0 = run_frac;
            if (b1 == run_bin) begin
               integral = ((longint'(u1) - longint'(u0)) *
                           interp(run_lo, run_hi, (u0 + u1) >> 1)) >>> 16;
            end else begin
               integral = ((longint'(ONE_Q32) - longint'(u0)) *
                           interp(run_lo, run_hi, (u0 + ONE_Q32) >> 1)) >>> 16;
               ia = run_bin + 1;
               if (ia > MAX_BINS) ia = MAX_BINS;
               integral += (longint'(ant_mem[b1]) - longint'(ant_mem[ia])) * 65536;
               integral += (longint'(u1) * interp(lo1, hi1, u1 >> 1)) >>> 16;
            end
            dp = delta * longint'(n);
            mag = scaled_quotient(integral < 0 ? longint'(-integral) : longint'(integral), dp);
            neg = (integral < 0) != (gain_reg < 0);
            g = gain_reg < 0 ? longint'(-longint'(gain_reg)) : longint'(gain_reg);
            if (g != 0 && mag > AVG_CAP / g) begin
               res = neg ? -64'sd2147483648 : 64'sd2147483647;
            end else begin
               prod = longint'(mag * g);
               if (neg) prod = -prod;
               res = (prod >>> 20) + longint'(offset_reg) + longint'($signed(it.base));
               if (res > 64'sd2147483647) res = 64'sd2147483647;
               if (res < -64'sd2147483648) res = -64'sd2147483648;
            end
            s.value = res[VAL_W-1:0];
         end
      end
      run_phase = it.ph;
      run_bin = b1;
      run_frac = u1;
      run_lo = lo1;
      run_hi = hi1;
   endfunction

   task automatic send_item(input step_row_type it);
      bit produced;
      sample_type s;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= it.act;
      req_table_index   <= it.idx;
      req_profile_value <= it.prof;
      req_antider_value <= it.ant;
      req_phase_value   <= it.ph;
      req_base_value    <= it.base;
      do @(posedge clock); while (!req_ready);
      predict_average(it, produced, s);
      if (it.typed) begin
         s.value = it.t_value;
         s.err = it.t_err;
      end
      if (produced) pending_samples.push_back(s);
   endtask

   // no result marks the end of a load or a start, so allow the block's latency too
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // leaves csr_valid high so writes can follow back to back
   task automatic write_csr(input logic [1:0] index, input logic [VAL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_BINS:   bins_reg = data[IDX_W-1:0];
         CSR_GAIN:   gain_reg = int'(data);
         CSR_OFFSET: offset_reg = int'(data);
         default: ;
      endcase
   endtask

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            hold = 400;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            hold = $urandom_range(0, 4);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      sample_type s;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: value %h err %b",
                                           rsp_sample_value, rsp_phase_error);
         end else begin
            s = pending_samples.pop_front();
            if (rsp_sample_value !== s.value || rsp_phase_error !== s.err) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value %h err %b, got value %h err %b",
                           s.value, s.err, rsp_sample_value, rsp_phase_error);
            end
         end
      end
   end

   function automatic step_row_type make_row(input logic [1:0] act,
                                             input logic [IDX_W-1:0] idx,
                                             input logic [PROF_W-1:0] prof,
                                             input logic [ANT_W-1:0] ant,
                                             input logic [PHASE_W-1:0] ph,
                                             input logic [VAL_W-1:0] base);
      step_row_type r;
      r.act = act;
      r.idx = idx;
      r.prof = prof;
      r.ant = ant;
      r.ph = ph;
      r.base = base;
      r.typed = 0;
      r.t_value = '0;
      r.t_err = 1'b0;
      return r;
   endfunction

   function automatic step_row_type random_row();
      step_row_type r;
      int k;
      longint unsigned adv;
      r = make_row(ACT_NEXT, IDX_W'($urandom), PROF_W'($urandom), $urandom,
                   PHASE_W'({$urandom, $urandom}), $urandom);
      k = $urandom_range(0, 99);
      if (k < 5) begin
         r.act = ACT_LOAD;
         r.idx = IDX_W'($urandom_range(0, MAX_BINS));
      end else if (k < 6) begin
         r.act = ACT_LOAD;
      end else if (k < 8) begin
         r.act = ACT_START;
      end else if (k < 9) begin
         r.act = ACT_NONE;
      end else begin
         k = $urandom_range(0, 19);
         if (k == 0) adv = 0;
         else if (k == 1) adv = {$urandom, $urandom};
         else if (k < 4) adv = $urandom_range(1, 16);
         else if (k < 13) adv = longint'($urandom >> $urandom_range(0, 31)) + 1;
         else adv = {$urandom_range(0, 3), $urandom};
         r.ph = run_phase + adv[PHASE_W-1:0];
      end
      // with more bins than were loaded keep the phase in the lowest 1/512 of the period
      if (eff_bins() > FILL_TOP) r.ph[FRAC_W-1:FRAC_W-9] = '0;
      return r;
   endfunction

   step_row_type directed [$];
   step_row_type row;
   logic [VAL_W-1:0] bins_set [NUM_PHASES];
   logic [VAL_W-1:0] gain_set [NUM_PHASES];
   logic [VAL_W-1:0] offs_set [NUM_PHASES];

   initial begin
      cycles = 0;
      mismatches = 0;
      calm = 0;
      long_hold_req = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_LOAD;
      req_table_index = '0;
      req_profile_value = '0;
      req_antider_value = '0;
      req_phase_value = '0;
      req_base_value = '0;
      csr_valid = 1'b0;
      csr_index = CSR_BINS;
      csr_data = '0;
      bins_reg = 13'd256;
      gain_reg = 65536;
      offset_reg = 0;
      run_open = 0;
      run_phase = '0;
      run_bin = 0;
      run_frac = 0;
      run_lo = 0;
      run_hi = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the low part of both tables; phases never reach past it
      for (int i = 0; i <= FILL_TOP; i++)
         send_item(make_row(ACT_LOAD, IDX_W'(i), PROF_W'($urandom), $urandom,
                            PHASE_W'({$urandom, $urandom}), $urandom));

      directed.push_back(make_row(ACT_LOAD, 13'd4097, 24'h7FFFFF, 32'h7FFFFFFF, 48'h0, 32'h0));
      directed.push_back(make_row(ACT_LOAD, 13'h1FFF, 24'h800000, 32'h80000000, 48'h0, 32'h0));
      directed.push_back(make_row(ACT_NEXT, 13'd0, 24'h0, 32'h0, 48'h0, 32'h0));
      row = make_row(ACT_NEXT, 13'd0, 24'h0, 32'h0, 48'h0, 32'h1234_5678);
      row.typed = 1;
      row.t_err = 1'b1;
      directed.push_back(row);
      directed.push_back(make_row(ACT_NEXT, 13'd0, 24'h0, 32'h0, 48'h0000_4000_0000, 32'h0));
      directed.push_back(make_row(ACT_NEXT, 13'd0, 24'h0, 32'h0, 48'h0000_4000_0001, 32'h0));
      row.ph = 48'h0000_2000_0000;
      directed.push_back(row);
      row.ph = 48'h8000_2000_0000;
      directed.push_back(row);
      directed.push_back(make_row(ACT_NONE, 13'h1FFF, 24'hFFFFFF, '1, '1, '1));
      directed.push_back(make_row(ACT_LOAD, 13'd0, 24'h800000, 32'h7FFFFFFF, 48'h0, 32'h0));
      directed.push_back(make_row(ACT_LOAD, 13'd1, 24'h7FFFFF, 32'h80000000, 48'h0, 32'h0));
      directed.push_back(make_row(ACT_LOAD, 13'd4096, 24'h0, 32'h0, 48'h0, 32'h0));
      directed.push_back(make_row(ACT_START, 13'd0, 24'h0, 32'h0, 48'hFFFF_FFFF_FFFF, 32'h0));
      directed.push_back(make_row(ACT_NEXT, 13'd0, 24'h0, 32'h0, 48'h0001_0000_0000,
                                  32'h7FFFFFFF));
      directed.push_back(make_row(ACT_NEXT, 13'd0, 24'h0, 32'h0, 48'h0001_0100_0000,
                                  32'h80000000));
      directed.push_back(make_row(ACT_NEXT, 13'd0, 24'h0, 32'h0, 48'h7FFF_FFFF_FFFF, 32'h0));
      directed.push_back(make_row(ACT_START, 13'd0, 24'h0, 32'h0, 48'h0, 32'h0));
      directed.push_back(make_row(ACT_NEXT, 13'd0, 24'h0, 32'h0, 48'h1, 32'h0));
      foreach (directed[i]) send_item(directed[i]);

      bins_set = '{32'd2, 32'd4096, 32'd0, 32'h1FFF, 32'd0, 32'd1, 32'd256};
      gain_set = '{32'd65536, 32'h7FFFFFFF, 32'h80000000, 32'd0, 32'd0,
                   32'hFFFF0000, 32'd65536};
      offs_set = '{32'd0, 32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd0, 32'd0, 32'd0};
      bins_set[4] = $urandom_range(2, MAX_BINS);
      gain_set[4] = $urandom;
      offs_set[4] = $urandom;
      offs_set[3] = $urandom;

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_csr(CSR_BINS, bins_set[p]);
         write_csr(CSR_GAIN, gain_set[p]);
         write_csr(CSR_OFFSET, offs_set[p]);
         csr_valid <= 1'b0;
         if (p == 2) long_hold_req = 1;
         if (p == NUM_PHASES - 1) calm = 1;
         for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_row());
      end

      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/ppia_pkg.sv
rtl/ppia_tables.sv
rtl/ppia_div.sv
rtl/periodic_profile_interval_average.sv
verif/tb_periodic_profile_interval_average.sv
